// File: hdl/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
package mts_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W  = 7;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_NOP  = 2'd2,
    OP_RSVD = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Push and pop strobes for one LIFO lane.
  typedef struct packed {
    logic push;
    logic pop;
  } lane_cmd_t;

endpackage

// File: hdl/mts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/mts_lifo_lane.sv
// One LIFO lane: top-of-stack register, entry count and backing RAM.
module mts_lifo_lane (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mts_pkg::lane_cmd_t       cmd,
  input  logic [mts_pkg::DATA_W-1:0] push_data,
  output logic [mts_pkg::CNT_W-1:0]  count,
  output logic [mts_pkg::DATA_W-1:0] top,
  output logic [mts_pkg::DATA_W-1:0] below
);
  import mts_pkg::*;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0]  rd_ptr;

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
      top_nxt   = push_data;
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
      top_nxt   = below;
    end
  end

  // Prefetch the entry under the next top so a pop can follow in the next cycle.
  assign rd_ptr = count_nxt - CNT_W'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  mts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (push_data),
    .rd_addr (rd_ptr[ADDR_W-1:0]),
    .rd_data (below)
  );

  assign count = count_r;
  assign top   = top_r;

endmodule

// File: hdl/min_tracking_stack_core.sv
// Top level of the min-tracking stack: handshakes, control and result register.
//
// Bounded LIFO of signed 32-bit values that also reports the minimum it holds.
// Each input transfer is a push, a pop or a status read (opcode 3 acts as a
// status read) and yields exactly one result transfer carrying status, the
// popped or top value, the minimum, the depth and an empty flag. One item is
// taken every cycle while in_ready is high, and its result appears in the output
// register in the next cycle; the top of each store lives in a register and the
// RAM read port prefetches the entry underneath, so pops and pushes can run back to back.
// A stalled result blocks new items only while it is not being taken. The
// capacity register (reset 64, above 64 acts as 64, 0 refuses every push) is
// written through the cfg port, which is always ready; write it while idle.
// No clearing pass is needed after reset.
module min_tracking_stack_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_opcode,
  input  logic signed [31:0]        in_push_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic signed [31:0]        out_item_value,
  output logic signed [31:0]        out_min_value,
  output logic [6:0]                out_depth,
  output logic                      out_is_empty,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mts_pkg::CAP_W-1:0] cfg_data
);
  import mts_pkg::*;

  // Configuration
  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] limit;

  // Lane state
  lane_cmd_t         val_cmd, min_cmd;
  logic [CNT_W-1:0]  val_cnt, min_cnt;
  logic [DATA_W-1:0] val_top, val_below, min_top, min_below;

  // Item decode
  logic              accept;
  logic              is_push, is_pop;
  logic              full, empty;
  logic [CNT_W-1:0]  val_cnt_new, min_cnt_new;
  status_t           status;
  logic [DATA_W-1:0] item, min_out;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        status_r;
  logic [DATA_W-1:0] item_r, min_r;
  logic [CNT_W-1:0]  depth_r;
  logic              empty_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_W'(DEPTH);
    end else if (cfg_valid) begin
      capacity_r <= cfg_data;
    end
  end

  // Saturate capacity to the built depth.
  always_comb begin
    if (CNT_W'(capacity_r) > CNT_W'(DEPTH)) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(capacity_r);
    end
  end

  // Take a new item whenever the result register is free or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_push = (in_opcode == OP_PUSH);
  assign is_pop  = (in_opcode == OP_POP);
  assign full    = (val_cnt >= limit);
  assign empty   = (val_cnt == '0);

  always_comb begin
    val_cmd.push = accept && is_push && !full;
    val_cmd.pop  = accept && is_pop && !empty;
    // Track a new minimum on ties too, so duplicates pop correctly.
    min_cmd.push = val_cmd.push &&
                   ((min_cnt == '0) || ($signed(in_push_value) <= $signed(min_top)));
    // Drop the min entry when the popped value is the current minimum.
    min_cmd.pop  = val_cmd.pop && (min_cnt != '0) && (min_top == val_top);
  end

  always_comb begin
    status = ST_OK;
    if (is_push && full) begin
      status = ST_FULL;
    end else if (is_pop && empty) begin
      status = ST_EMPTY;
    end
  end

  always_comb begin
    val_cnt_new = val_cnt;
    if (val_cmd.push) begin
      val_cnt_new = val_cnt + CNT_W'(1);
    end else if (val_cmd.pop) begin
      val_cnt_new = val_cnt - CNT_W'(1);
    end

    min_cnt_new = min_cnt;
    if (min_cmd.push) begin
      min_cnt_new = min_cnt + CNT_W'(1);
    end else if (min_cmd.pop) begin
      min_cnt_new = min_cnt - CNT_W'(1);
    end

    // Report the popped value on a pop, else the top after the step (zero when empty).
    if (val_cmd.pop) begin
      item = val_top;
    end else if (val_cmd.push) begin
      item = in_push_value;
    end else if (!empty) begin
      item = val_top;
    end else begin
      item = '0;
    end

    if (val_cnt_new == '0 || min_cnt_new == '0) begin
      min_out = '0;
    end else if (min_cmd.push) begin
      min_out = in_push_value;
    end else if (min_cmd.pop) begin
      min_out = min_below;
    end else begin
      min_out = min_top;
    end
  end

  mts_lifo_lane u_val_lane (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (val_cmd),
    .push_data (in_push_value),
    .count     (val_cnt),
    .top       (val_top),
    .below     (val_below)
  );

  mts_lifo_lane u_min_lane (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (min_cmd),
    .push_data (in_push_value),
    .count     (min_cnt),
    .top       (min_top),
    .below     (min_below)
  );

  // Hold the result until the transfer completes; load on every accept.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status;
      item_r   <= item;
      min_r    <= min_out;
      depth_r  <= val_cnt_new;
      empty_r  <= (val_cnt_new == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_item_value = item_r;
  assign out_min_value  = min_r;
  assign out_depth      = 7'(depth_r);
  assign out_is_empty   = empty_r;

endmodule
